>>> rtl/core/rdg_pkg.sv
// shared types, constants and tempering function of the random distribution generator
package rdg_pkg;

   localparam int MT_N    = 624;
   localparam int MT_M    = 397;
   localparam int ADDR_W  = 10;
   localparam int VALUE_W = 40;

   localparam logic [30:0] SEED_RESET  = 31'd5489;
   localparam logic [31:0] SEED_MULT   = 32'd1812433253;
   localparam logic [31:0] MATRIX_A    = 32'h9908B0DF;
   localparam logic [31:0] WORD_MAX    = 32'hFFFFFFFF;
   localparam logic [31:0] GAUSS_SCALE = 32'd1121401383;

   typedef enum logic [1:0] {
      OP_UNIFORM  = 2'd0,
      OP_LINEAR   = 2'd1,
      OP_TRIANGLE = 2'd2,
      OP_GAUSS    = 2'd3
   } rdg_op_type;

   typedef enum logic [2:0] {
      ST_SEED_INIT,
      ST_SEED,
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_MUL_LO,
      ST_MUL_HI
   } rdg_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       seed_init;
      logic       seed_step;
      logic       load_op;
      logic       draw_rd;
      logic       draw_wr;
      logic       mul_lo;
      logic       mul_hi;
      logic       second;
      logic       out_load;
      rdg_op_type op;
   } rdg_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic seed_last;
   } rdg_status_type;

   // standard output tempering
   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9D2C5680);
      y = y ^ ((y << 15) & 32'hEFC60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

>>> rtl/core/rdg_ctrl.sv
// controller state machine of the random distribution generator
module rdg_ctrl #(
   parameter int GAUSS_TERMS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_op,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    csr_write,
   input  rdg_pkg::rdg_status_type status,
   output rdg_pkg::rdg_cmd_type    cmd
);

   localparam int CNT_W = $clog2(GAUSS_TERMS + 1);

   rdg_pkg::rdg_state_type state_ff, state_in;
   rdg_pkg::rdg_op_type    op_ff, op_in;
   logic [CNT_W-1:0]       words_ff, words_in;
   logic                   second_ff, second_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rdg_pkg::ST_SEED_INIT;
         op_ff        <= rdg_pkg::OP_UNIFORM;
         words_ff     <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         words_ff     <= words_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      words_in     = words_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.second   = second_ff;
      unique case (state_ff)
         rdg_pkg::ST_SEED_INIT: begin
            cmd.seed_init = 1'b1;
            state_in      = rdg_pkg::ST_SEED;
         end
         rdg_pkg::ST_SEED: begin
            cmd.seed_step = 1'b1;
            if (status.seed_last) state_in = rdg_pkg::ST_IDLE;
         end
         rdg_pkg::ST_IDLE: begin
            cmd.op = rdg_pkg::rdg_op_type'(req_op);
            if (req_valid) begin
               cmd.load_op = 1'b1;
               op_in       = rdg_pkg::rdg_op_type'(req_op);
               second_in   = 1'b0;
               unique case (rdg_pkg::rdg_op_type'(req_op))
                  rdg_pkg::OP_UNIFORM:  words_in = CNT_W'(1);
                  rdg_pkg::OP_LINEAR:   words_in = CNT_W'(2);
                  rdg_pkg::OP_TRIANGLE: words_in = CNT_W'(2);
                  rdg_pkg::OP_GAUSS:    words_in = CNT_W'(GAUSS_TERMS);
               endcase
               state_in = rdg_pkg::ST_READ;
            end
         end
         rdg_pkg::ST_READ: begin
            cmd.draw_rd = 1'b1;
            state_in    = rdg_pkg::ST_WRITE;
         end
         rdg_pkg::ST_WRITE: begin
            cmd.draw_wr = 1'b1;
            words_in    = words_ff - CNT_W'(1);
            state_in    = (words_ff == CNT_W'(1)) ? rdg_pkg::ST_MUL_LO : rdg_pkg::ST_READ;
         end
         rdg_pkg::ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = rdg_pkg::ST_MUL_HI;
         end
         rdg_pkg::ST_MUL_HI: begin
            if (op_ff == rdg_pkg::OP_GAUSS && !second_ff) begin
               cmd.mul_hi = 1'b1;
               second_in  = 1'b1;
               state_in   = rdg_pkg::ST_MUL_LO;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               second_in    = 1'b0;
               state_in     = rdg_pkg::ST_IDLE;
            end
         end
         default: state_in = rdg_pkg::ST_SEED_INIT;
      endcase
      // a seed write restarts the fill
      if (csr_write) state_in = rdg_pkg::ST_SEED_INIT;
   end

   assign req_stall = (state_ff != rdg_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // seed write always leads into a fresh fill
   a_seed_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> state_ff == rdg_pkg::ST_SEED_INIT)
      else $error("seed write did not restart fill");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   // a read is only issued while words remain
   a_words_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == rdg_pkg::ST_READ |-> words_ff != '0)
      else $error("draw without remaining words");

   // second multiply pass only for gaussian
   a_second_gauss: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> op_ff == rdg_pkg::OP_GAUSS)
      else $error("second pass outside gaussian mode");

endmodule

>>> rtl/core/rdg_dp.sv
// datapath: twister state memory, seeding, word shaping and split multiplier
module rdg_dp #(
   parameter int GAUSS_TERMS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [30:0]                          csr_seed,
   input  logic signed [31:0]                   req_range,
   input  rdg_pkg::rdg_cmd_type                 cmd,
   output rdg_pkg::rdg_status_type              status,
   output logic signed [rdg_pkg::VALUE_W-1:0]   rsp_value
);

   localparam int SUM_W = 33 + $clog2(GAUSS_TERMS);
   localparam int AW    = rdg_pkg::ADDR_W;
   localparam int VW    = rdg_pkg::VALUE_W;
   localparam logic [SUM_W-1:0] GAUSS_OFF =
      SUM_W'((64'(GAUSS_TERMS) * 64'(rdg_pkg::WORD_MAX)) >> 1);

   logic [31:0]            mt_mem [rdg_pkg::MT_N];
   logic [30:0]            seed_ff;
   logic [AW-1:0]          cnt_ff, cnt_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [31:0]            prev_ff, prev_in;
   logic [31:0]            cur_ff, cur_in;
   logic [31:0]            rd1_ff, rd2_ff;
   logic signed [31:0]     range_ff;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic signed [64:0]     p1_ff;
   logic signed [VW-1:0]   p_ff;
   logic signed [VW-1:0]   value_ff;

   logic [31:0]            mix, seed_word, y, twisted, tword;
   logic [AW-1:0]          addr1, addr2;
   logic signed [VW-1:0]   op_a, result, prod_hi;
   logic signed [31:0]     op_b;
   logic signed [32:0]     a_lo;
   logic signed [SUM_W-1:0] tword_ext;

   // seed register
   always_ff @(posedge clock) begin
      if (reset) seed_ff <= rdg_pkg::SEED_RESET;
      else if (csr_write) seed_ff <= csr_seed;
   end

   // seeding recurrence
   assign mix       = prev_ff ^ (prev_ff >> 30);
   assign seed_word = mix * rdg_pkg::SEED_MULT + 32'(cnt_ff);

   // read addresses for the next-word and far taps
   assign addr1 = (pos_ff == AW'(rdg_pkg::MT_N - 1)) ? '0 : pos_ff + AW'(1);
   assign addr2 = (pos_ff >= AW'(rdg_pkg::MT_N - rdg_pkg::MT_M))
                  ? pos_ff - AW'(rdg_pkg::MT_N - rdg_pkg::MT_M)
                  : pos_ff + AW'(rdg_pkg::MT_M);

   // twist of one word and tempering
   assign y       = {cur_ff[31], rd1_ff[30:0]};
   assign twisted = rd2_ff ^ (y >> 1) ^ (y[0] ? rdg_pkg::MATRIX_A : 32'd0);
   assign tword   = rdg_pkg::temper(twisted);
   assign tword_ext = $signed({{(SUM_W-32){1'b0}}, tword});

   // state memory
   always_ff @(posedge clock) begin
      if (cmd.seed_init) mt_mem[0] <= {1'b0, seed_ff};
      else if (cmd.seed_step) mt_mem[cnt_ff] <= seed_word;
      else if (cmd.draw_wr) mt_mem[pos_ff] <= twisted;
      if (cmd.draw_rd) begin
         rd1_ff <= mt_mem[addr1];
         rd2_ff <= mt_mem[addr2];
      end
   end

   // seeding and draw pointers
   always_comb begin
      cnt_in  = cnt_ff;
      prev_in = prev_ff;
      pos_in  = pos_ff;
      cur_in  = cur_ff;
      if (cmd.seed_init) begin
         cnt_in  = AW'(1);
         prev_in = {1'b0, seed_ff};
         cur_in  = {1'b0, seed_ff};
         pos_in  = '0;
      end else if (cmd.seed_step) begin
         cnt_in  = cnt_ff + AW'(1);
         prev_in = seed_word;
      end else if (cmd.draw_wr) begin
         cur_in = rd1_ff;
         pos_in = addr1;
      end
   end

   // word accumulator per distribution
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load_op) begin
         unique case (cmd.op)
            rdg_pkg::OP_UNIFORM:  acc_in = '0;
            rdg_pkg::OP_LINEAR:   acc_in = $signed(SUM_W'(rdg_pkg::WORD_MAX));
            rdg_pkg::OP_TRIANGLE: acc_in = $signed(SUM_W'(0) - SUM_W'(rdg_pkg::WORD_MAX));
            rdg_pkg::OP_GAUSS:    acc_in = $signed(SUM_W'(0) - GAUSS_OFF);
         endcase
      end else if (cmd.draw_wr) begin
         if (cmd.op == rdg_pkg::OP_LINEAR)
            acc_in = (tword < acc_ff[31:0]) ? tword_ext : acc_ff;
         else
            acc_in = acc_ff + tword_ext;
      end
   end

   // split multiplier: low 32 bits of a first, high bits second
   assign op_a    = cmd.second ? p_ff : VW'(acc_ff);
   assign op_b    = cmd.second ? $signed(rdg_pkg::GAUSS_SCALE) : range_ff;
   assign a_lo    = $signed({1'b0, op_a[31:0]});
   assign prod_hi = $signed(op_a[VW-1:32]) * op_b;
   assign result  = VW'($signed(p1_ff[64:32])) + prod_hi;

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      acc_ff  <= acc_in;
      if (cmd.load_op) range_ff <= req_range;
      if (cmd.mul_lo) p1_ff <= a_lo * op_b;
      if (cmd.mul_hi) p_ff <= result;
      if (cmd.out_load) value_ff <= result;
   end

   assign status.seed_last = (cnt_ff == AW'(rdg_pkg::MT_N - 1));
   assign rsp_value        = value_ff;

endmodule

>>> rtl/core/random_distribution_generator.sv
// top level of the random distribution generator
//
// channel  direction  handshake           payload
// req      in         req_valid/req_stall req_op[1:0], req_range[31:0] signed Q16.16
// rsp      out        rsp_valid/rsp_stall rsp_value[39:0] signed Q24.16
// csr      in         csr_valid/csr_ready csr_seed[30:0]
//
// each twister word is drawn as the two state-memory reads, then the twist, write-back
// and accumulate; a multiply pass takes the low 32 operand bits, then the high bits
// uniform draws one word, linear and triangle two, gaussian GAUSS_TERMS words
// after reset and after every seed write the state memory is filled anew from the seed
// reset is synchronous; req_stall is high while a transaction or the fill is in work
// a finished result waits in the output register while the next transaction is taken
module random_distribution_generator #(
   parameter int GAUSS_TERMS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic signed [31:0]  req_range,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [39:0]  rsp_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [30:0]         csr_seed
);

   rdg_pkg::rdg_cmd_type    cmd;
   rdg_pkg::rdg_status_type status;
   logic                    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   rdg_ctrl #(.GAUSS_TERMS(GAUSS_TERMS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_write (csr_write),
      .status    (status),
      .cmd       (cmd)
   );

   rdg_dp #(.GAUSS_TERMS(GAUSS_TERMS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_seed  (csr_seed),
      .req_range (req_range),
      .cmd       (cmd),
      .status    (status),
      .rsp_value (rsp_value)
   );

endmodule
